@@ hw/rtl/torq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torq_pkg
// Types, constants and key compare shared by the request queue and its cells.
// ----------------------------------------------------------------------------
package torq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_W            = 8;
   localparam int STAMP_W         = 31;
   localparam int TYPE_W          = 4;
   localparam int OUT_COUNT_W     = 5;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [STAMP_W-1:0] stamp;
      logic [TYPE_W-1:0]  rtype;
   } entry_type;

   // broadcast to every cell each cycle
   typedef struct packed {
      logic      insert;
      entry_type entry;
   } cell_ctrl_type;

   // held key a is ordered at or before new key b
   function automatic logic key_le(entry_type a, entry_type b);
      logic res;
      if (a.stamp != b.stamp) begin
         res = (a.stamp < b.stamp);
      end else begin
         res = (a.id <= b.id);
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/torq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torq_cell
// One slot of the sorted row: holds, takes the new request, or shifts right.
// ----------------------------------------------------------------------------
module torq_cell #(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 5
) (
   input  logic                   clock,
   input  torq_pkg::cell_ctrl_type ctrl,
   input  logic [COUNT_W-1:0]     count,
   input  torq_pkg::entry_type    left_entry,
   input  logic                   left_keep,
   output torq_pkg::entry_type    entry,
   output logic                   keep
);
   import torq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      valid;

   assign valid = (COUNT_W'(INDEX) < count);
   assign keep  = valid && key_le(entry_ff, ctrl.entry);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && !keep) begin
         // first slot past the last smaller-or-equal key takes the request
         if (left_keep) begin
            entry_in = ctrl.entry;
         end else begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ hw/rtl/timestamp_ordered_request_queue.sv @@
`timescale 1ns / 1ps
// A request's response is registered and shows in the cycle after accept.
// Throughput: one request per cycle while req_stall is low; the cell row updates all slots at once.
// req_stall follows only a held, stalled response.
// Reset: fill count and response valid clear; slot contents stay undefined
// and are never read before written.
// ----------------------------------------------------------------------------
// timestamp_ordered_request_queue
// Bounded queue sorted by timestamp then process id, built from a cell row.
// ----------------------------------------------------------------------------
module timestamp_ordered_request_queue #(
   parameter int QUEUE_DEPTH = torq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [torq_pkg::ID_W-1:0]    req_proc_id,
   input  logic [torq_pkg::STAMP_W-1:0] req_stamp,
   input  logic [torq_pkg::TYPE_W-1:0]  req_req_kind,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_head_valid,
   output logic [torq_pkg::ID_W-1:0]    rsp_head_id,
   output logic [torq_pkg::STAMP_W-1:0] rsp_head_stamp,
   output logic [torq_pkg::TYPE_W-1:0]  rsp_head_kind,
   output logic [torq_pkg::OUT_COUNT_W-1:0] rsp_entry_count,
   output logic                         rsp_dropped
);
   import torq_pkg::*;

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                 accept;
   logic                 full;
   logic                 do_insert;
   cell_ctrl_type        ctrl;
   entry_type            new_entry;
   entry_type            cell_entry [QUEUE_DEPTH];
   logic                 cell_keep  [QUEUE_DEPTH];

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   entry_type            head_ff, head_in;
   logic                 head_valid_ff, head_valid_in;
   logic                 dropped_ff, dropped_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign do_insert = accept && (req_kind == KIND_INSERT) && !full;

   assign new_entry.id    = req_proc_id;
   assign new_entry.stamp = req_stamp;
   assign new_entry.rtype = req_req_kind;
   assign ctrl.insert     = do_insert;
   assign ctrl.entry      = new_entry;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         torq_cell #(.INDEX(i), .COUNT_W(COUNT_W)) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .count      (count_ff),
            .left_entry (new_entry),
            .left_keep  (1'b1),
            .entry      (cell_entry[i]),
            .keep       (cell_keep[i])
         );
      end else begin : g_rest
         torq_cell #(.INDEX(i), .COUNT_W(COUNT_W)) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .count      (count_ff),
            .left_entry (cell_entry[i-1]),
            .left_keep  (cell_keep[i-1]),
            .entry      (cell_entry[i]),
            .keep       (cell_keep[i])
         );
      end
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      dropped_in    = dropped_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         dropped_in   = 1'b0;
         if (req_kind == KIND_CLEAR) begin
            count_in = '0;
         end else if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + COUNT_W'(1);
         end
         // head after this request, taken from slot 0's next value
         if (do_insert && !cell_keep[0]) begin
            head_in = new_entry;
         end else begin
            head_in = cell_entry[0];
         end
         head_valid_in = (count_in != '0);
         if (!head_valid_in) begin
            head_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_ff       <= head_in;
      head_valid_ff <= head_valid_in;
      dropped_ff    <= dropped_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_head_valid  = head_valid_ff;
   assign rsp_head_id     = head_ff.id;
   assign rsp_head_stamp  = head_ff.stamp;
   assign rsp_head_kind   = head_ff.rtype;
   assign rsp_entry_count = OUT_COUNT_W'(count_ff);
   assign rsp_dropped     = dropped_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("fill count above queue depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_CLEAR) |=> (count_ff == '0 && rsp_valid_ff))
      else $error("clear did not empty the queue");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && dropped_ff) |-> full)
      else $error("drop reported on a queue that is not full");

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (head_valid_ff == (count_ff != '0)))
      else $error("head valid disagrees with fill count");
`endif

endmodule
